// File: hw/rtl/key_repeat_cursor_blink_macros.svh
// Assertion macros used by the key repeat and cursor blink checker.
`ifndef KEY_REPEAT_CURSOR_BLINK_MACROS_SVH
`define KEY_REPEAT_CURSOR_BLINK_MACROS_SVH

// Property checked on every clock edge outside reset.
`define KRCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define KRCB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hw/rtl/krcb_pkg.sv
// Shared types and constants of the key repeat and cursor blink block.
`default_nettype none
package krcb_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned INDEX_W = 2;

    localparam logic [INDEX_W-1:0] REG_INITIAL_DELAY   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;
    localparam logic [INDEX_W-1:0] REG_FLASH_PERIOD    = 2'd2;
    localparam logic [INDEX_W-1:0] REG_SCREEN_COLOUR   = 2'd3;

    localparam logic [DATA_W-1:0] RST_INITIAL_DELAY   = 8'd20;
    localparam logic [DATA_W-1:0] RST_REPEAT_INTERVAL = 8'd4;
    localparam logic [DATA_W-1:0] RST_FLASH_PERIOD    = 8'd16;
    localparam logic [DATA_W-1:0] RST_SCREEN_COLOUR   = 8'd0;

    localparam logic [DATA_W-1:0] KEY_NONE      = 8'd0;
    localparam logic [DATA_W-1:0] UPPER_BELOW   = 8'd64;
    localparam logic [DATA_W-1:0] UPPER_ABOVE   = 8'd91;
    localparam logic [DATA_W-1:0] CASE_OFFSET   = 8'd32;
    localparam logic [DATA_W-1:0] BLINK_TOGGLE  = 8'd128;

    typedef struct packed {
        logic [DATA_W-1:0] initial_delay;
        logic [DATA_W-1:0] repeat_interval;
        logic [DATA_W-1:0] flash_period;
        logic [DATA_W-1:0] screen_colour;
    } cfg_t;

    typedef struct packed {
        logic              key_valid;
        logic [DATA_W-1:0] key_code;
        logic [DATA_W-1:0] cursor_attr;
    } res_t;

    function automatic logic [DATA_W-1:0] fold_case(input logic [DATA_W-1:0] c);
        if (c > UPPER_BELOW && c < UPPER_ABOVE) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/krcb_cfg.sv
// Configuration register file of the key repeat and cursor blink block.
`default_nettype none
module krcb_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [krcb_pkg::INDEX_W-1:0]  wr_index,
    input  wire logic [krcb_pkg::DATA_W-1:0]   wr_data,
    output krcb_pkg::cfg_t                     cfg
);

    krcb_pkg::cfg_t cfg_reg;
    krcb_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                krcb_pkg::REG_INITIAL_DELAY:   cfg_next.initial_delay   = wr_data;
                krcb_pkg::REG_REPEAT_INTERVAL: cfg_next.repeat_interval = wr_data;
                krcb_pkg::REG_FLASH_PERIOD:    cfg_next.flash_period    = wr_data;
                krcb_pkg::REG_SCREEN_COLOUR:   cfg_next.screen_colour   = wr_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_delay   <= krcb_pkg::RST_INITIAL_DELAY;
            cfg_reg.repeat_interval <= krcb_pkg::RST_REPEAT_INTERVAL;
            cfg_reg.flash_period    <= krcb_pkg::RST_FLASH_PERIOD;
            cfg_reg.screen_colour   <= krcb_pkg::RST_SCREEN_COLOUR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: hw/rtl/krcb_core.sv
// Poll state update: key repeat countdown, held key and cursor blink.
`default_nettype none
module krcb_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire krcb_pkg::cfg_t              cfg,
    input  wire logic                        step,
    input  wire logic [krcb_pkg::DATA_W-1:0] key,
    output krcb_pkg::res_t                   res
);

    logic [krcb_pkg::DATA_W-1:0] held_key_reg, held_key_next;
    logic [krcb_pkg::DATA_W-1:0] repeat_count_reg, repeat_count_next;
    logic [krcb_pkg::DATA_W-1:0] flash_count_reg, flash_count_next;
    logic [krcb_pkg::DATA_W-1:0] attr_reg, attr_next;
    logic                        awaiting_reg, awaiting_next;
    logic                        deliver;
    logic [krcb_pkg::DATA_W-1:0] repeat_dec;
    logic [krcb_pkg::DATA_W-1:0] flash_dec;

    assign repeat_dec = repeat_count_reg - 8'd1;
    assign flash_dec  = flash_count_reg - 8'd1;

    always_comb begin
        deliver           = 1'b0;
        repeat_count_next = repeat_count_reg;
        awaiting_next     = awaiting_reg;
        held_key_next     = held_key_reg;
        flash_count_next  = flash_count_reg;
        attr_next         = attr_reg;

        if (awaiting_reg) begin
            if (key == krcb_pkg::KEY_NONE) begin
                repeat_count_next = cfg.initial_delay;
            end else begin
                deliver = 1'b1;
            end
        end else begin
            priority if (key == krcb_pkg::KEY_NONE) begin
                repeat_count_next = cfg.initial_delay;
                awaiting_next     = 1'b1;
            end else if (krcb_pkg::fold_case(key) == krcb_pkg::fold_case(held_key_reg)) begin
                if (repeat_dec == '0) begin
                    repeat_count_next = cfg.repeat_interval;
                    awaiting_next     = 1'b1;
                end else begin
                    repeat_count_next = repeat_dec;
                end
            end else begin
                repeat_count_next = cfg.initial_delay;
                deliver           = 1'b1;
            end
        end

        if (deliver) begin
            held_key_next    = key;
            awaiting_next    = 1'b0;
            attr_next        = cfg.screen_colour;
            flash_count_next = cfg.flash_period;
        end else if (flash_dec == '0) begin
            attr_next        = attr_reg ^ krcb_pkg::BLINK_TOGGLE;
            flash_count_next = cfg.flash_period;
        end else begin
            flash_count_next = flash_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_key_reg     <= krcb_pkg::KEY_NONE;
            repeat_count_reg <= krcb_pkg::RST_INITIAL_DELAY;
            flash_count_reg  <= krcb_pkg::RST_FLASH_PERIOD;
            attr_reg         <= krcb_pkg::RST_SCREEN_COLOUR;
            awaiting_reg     <= 1'b0;
        end else if (step) begin
            held_key_reg     <= held_key_next;
            repeat_count_reg <= repeat_count_next;
            flash_count_reg  <= flash_count_next;
            attr_reg         <= attr_next;
            awaiting_reg     <= awaiting_next;
        end
    end

    assign res.key_valid   = deliver;
    assign res.key_code    = deliver ? key : krcb_pkg::KEY_NONE;
    assign res.cursor_attr = attr_next;

endmodule
`default_nettype wire

// File: hw/rtl/krcb_outq.sv
// Result register with a skid stage, so that a poll is taken while a result waits.
`default_nettype none
module krcb_outq (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire krcb_pkg::res_t push_res,
    output logic                can_push,
    output logic                out_valid,
    input  wire logic           out_ready,
    output krcb_pkg::res_t      out_res
);

    logic           head_valid_reg, head_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    krcb_pkg::res_t head_reg, head_next;
    krcb_pkg::res_t skid_reg, skid_next;
    logic           pop;

    assign pop = head_valid_reg && out_ready;

    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (push) begin
            if (!head_valid_reg || pop) begin
                head_valid_next = 1'b1;
                head_next       = push_res;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = push_res;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                head_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_res   = head_reg;

endmodule
`default_nettype wire

// File: hw/rtl/key_repeat_cursor_blink.sv
// Top level of the keyboard typematic repeat with blinking cursor attribute.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_pressed_key
//  m_        out        m_valid/m_ready    m_key_valid, m_key_code, m_cursor_attr
//  cfg_wr_   in         cfg_wr_en only     cfg_wr_index, cfg_wr_data
//
// One poll is taken per cycle while s_ready is high; its result reaches m_ registered.
// The state update is a single pass of logic from the poll into a two-entry result buffer.
// A stalled m_ side is absorbed by the skid entry; s_ready falls only once both are full.
// Synchronous reset empties the buffer and returns state and registers to their defaults.
`default_nettype none
module key_repeat_cursor_blink (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [krcb_pkg::DATA_W-1:0]   s_pressed_key,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_key_valid,
    output logic [krcb_pkg::DATA_W-1:0]        m_key_code,
    output logic [krcb_pkg::DATA_W-1:0]        m_cursor_attr,
    input  wire logic                          cfg_wr_en,
    input  wire logic [krcb_pkg::INDEX_W-1:0]  cfg_wr_index,
    input  wire logic [krcb_pkg::DATA_W-1:0]   cfg_wr_data
);

    krcb_pkg::cfg_t cfg;
    krcb_pkg::res_t step_res;
    krcb_pkg::res_t out_res;
    logic           step;

    assign step = s_valid && s_ready;

    krcb_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_wr_index),
        .wr_data  (cfg_wr_data),
        .cfg      (cfg)
    );

    krcb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .key     (s_pressed_key),
        .res     (step_res)
    );

    krcb_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step),
        .push_res  (step_res),
        .can_push  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_key_valid   = out_res.key_valid;
    assign m_key_code    = out_res.key_code;
    assign m_cursor_attr = out_res.cursor_attr;

endmodule
`default_nettype wire

// File: hw/rtl/krcb_checker.sv
// Port-level checker for the key repeat and cursor blink block, with its bind.
`default_nettype none
`include "key_repeat_cursor_blink_macros.svh"
module krcb_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic                        m_key_valid,
    input wire logic [krcb_pkg::DATA_W-1:0] m_key_code,
    input wire logic [krcb_pkg::DATA_W-1:0] m_cursor_attr
);

    `KRCB_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid, "result pending after reset")
    `KRCB_ASSERT(a_no_key_code_zero, m_valid && !m_key_valid |-> m_key_code == krcb_pkg::KEY_NONE, "key code set without a key")
    `KRCB_ASSERT(a_key_nonzero, m_valid && m_key_valid |-> m_key_code != krcb_pkg::KEY_NONE, "delivered key is no key")
    `KRCB_ASSERT(a_stall_holds, m_valid && !m_ready |=> m_valid && $stable(m_cursor_attr), "stalled result changed")

endmodule

bind key_repeat_cursor_blink krcb_checker u_krcb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_key_valid   (m_key_valid),
    .m_key_code    (m_key_code),
    .m_cursor_attr (m_cursor_attr)
);
`default_nettype wire

// File: sim/key_repeat_cursor_blink_tb.sv
// Self-checking testbench for the key repeat and cursor blink block.
`default_nettype none
module key_repeat_cursor_blink_tb;

    localparam logic [krcb_pkg::DATA_W-1:0] LETTER_A   = 8'h41;
    localparam logic [krcb_pkg::DATA_W-1:0] LETTER_Z   = 8'h5A;
    localparam logic [krcb_pkg::DATA_W-1:0] CASE_BIT   = 8'h20;
    localparam logic [krcb_pkg::DATA_W-1:0] BACKTICK   = 8'h60;
    localparam logic [krcb_pkg::DATA_W-1:0] OPEN_BRACE = 8'h7B;
    localparam logic [krcb_pkg::DATA_W-1:0] KEY_LOWEST = 8'h01;
    localparam logic [krcb_pkg::DATA_W-1:0] KEY_TOP    = 8'hFF;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [krcb_pkg::DATA_W-1:0]  s_pressed_key = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_key_valid;
    logic [krcb_pkg::DATA_W-1:0]  m_key_code;
    logic [krcb_pkg::DATA_W-1:0]  m_cursor_attr;
    logic                         cfg_wr_en = 1'b0;
    logic [krcb_pkg::INDEX_W-1:0] cfg_wr_index = '0;
    logic [krcb_pkg::DATA_W-1:0]  cfg_wr_data = '0;

    key_repeat_cursor_blink u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pressed_key (s_pressed_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_valid   (m_key_valid),
        .m_key_code    (m_key_code),
        .m_cursor_attr (m_cursor_attr),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the block's registers and typematic state.
    krcb_pkg::cfg_t              shadow_cfg;
    logic [krcb_pkg::DATA_W-1:0] held_key;
    logic [krcb_pkg::DATA_W-1:0] repeat_left;
    logic [krcb_pkg::DATA_W-1:0] blink_left;
    logic [krcb_pkg::DATA_W-1:0] attr_shadow;
    logic                        awaiting_press;

    krcb_pkg::res_t poll_results_due[$];
    krcb_pkg::res_t seen_result;
    krcb_pkg::res_t due_result;

    bit          idling = 1'b1;
    int unsigned stall_left = 0;
    int unsigned mismatches = 0;
    int unsigned polls_checked = 0;
    int unsigned keys_delivered = 0;
    int unsigned cursor_flips = 0;
    int unsigned settings_used = 1;

    function automatic logic [krcb_pkg::DATA_W-1:0] letter_to_lower(
        input logic [krcb_pkg::DATA_W-1:0] c);
        return (c >= LETTER_A && c <= LETTER_Z) ? (c | CASE_BIT) : c;
    endfunction

    function automatic void reset_typematic_state();
        shadow_cfg     = '{krcb_pkg::RST_INITIAL_DELAY, krcb_pkg::RST_REPEAT_INTERVAL,
                           krcb_pkg::RST_FLASH_PERIOD, krcb_pkg::RST_SCREEN_COLOUR};
        held_key       = krcb_pkg::KEY_NONE;
        repeat_left    = krcb_pkg::RST_INITIAL_DELAY;
        blink_left     = krcb_pkg::RST_FLASH_PERIOD;
        attr_shadow    = krcb_pkg::RST_SCREEN_COLOUR;
        awaiting_press = 1'b0;
    endfunction

    function automatic krcb_pkg::res_t predict_poll(input logic [krcb_pkg::DATA_W-1:0] key);
        krcb_pkg::res_t r;
        logic deliver;
        deliver = 1'b0;
        if (awaiting_press) begin
            if (key == krcb_pkg::KEY_NONE) begin
                repeat_left = shadow_cfg.initial_delay;
            end else begin
                deliver = 1'b1;
            end
        end else if (key == krcb_pkg::KEY_NONE) begin
            repeat_left    = shadow_cfg.initial_delay;
            awaiting_press = 1'b1;
        end else if (letter_to_lower(key) == letter_to_lower(held_key)) begin
            repeat_left = repeat_left - 8'd1;
            if (repeat_left == '0) begin
                repeat_left    = shadow_cfg.repeat_interval;
                awaiting_press = 1'b1;
            end
        end else begin
            repeat_left = shadow_cfg.initial_delay;
            deliver     = 1'b1;
        end
        if (deliver) begin
            held_key       = key;
            awaiting_press = 1'b0;
            attr_shadow    = shadow_cfg.screen_colour;
            blink_left     = shadow_cfg.flash_period;
            keys_delivered++;
        end else begin
            blink_left = blink_left - 8'd1;
            if (blink_left == '0) begin
                attr_shadow = attr_shadow ^ krcb_pkg::BLINK_TOGGLE;
                blink_left  = shadow_cfg.flash_period;
                cursor_flips++;
            end
        end
        r.key_valid   = deliver;
        r.key_code    = deliver ? key : krcb_pkg::KEY_NONE;
        r.cursor_attr = attr_shadow;
        return r;
    endfunction

    // Result side: random stall bursts while idling is set, and each transfer checked against the oldest poll.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                seen_result = '{m_key_valid, m_key_code, m_cursor_attr};
                if (poll_results_due.size() == 0) begin
                    $error("result transfer with no poll outstanding");
                    mismatches++;
                end else begin
                    due_result = poll_results_due.pop_front();
                    polls_checked++;
                    if (seen_result.key_valid !== due_result.key_valid) begin
                        $error("key_valid: expected %0b, got %0b",
                               due_result.key_valid, seen_result.key_valid);
                        mismatches++;
                    end
                    if (seen_result.key_code !== due_result.key_code) begin
                        $error("key_code: expected 0x%02h, got 0x%02h",
                               due_result.key_code, seen_result.key_code);
                        mismatches++;
                    end
                    if (seen_result.cursor_attr !== due_result.cursor_attr) begin
                        $error("cursor_attr: expected 0x%02h, got 0x%02h",
                               due_result.cursor_attr, seen_result.cursor_attr);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_poll(input logic [krcb_pkg::DATA_W-1:0] key);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pressed_key <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        poll_results_due.push_back(predict_poll(key));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (poll_results_due.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic load_config(input krcb_pkg::cfg_t c);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= krcb_pkg::REG_INITIAL_DELAY;
        cfg_wr_data  <= c.initial_delay;
        @(posedge aclk);
        cfg_wr_index <= krcb_pkg::REG_REPEAT_INTERVAL;
        cfg_wr_data  <= c.repeat_interval;
        @(posedge aclk);
        cfg_wr_index <= krcb_pkg::REG_FLASH_PERIOD;
        cfg_wr_data  <= c.flash_period;
        @(posedge aclk);
        cfg_wr_index <= krcb_pkg::REG_SCREEN_COLOUR;
        cfg_wr_data  <= c.screen_colour;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        shadow_cfg = c;
        settings_used++;
    endtask

    function automatic krcb_pkg::cfg_t random_config();
        krcb_pkg::cfg_t c;
        c.initial_delay   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                        : 8'($urandom_range(1, 12));
        c.repeat_interval = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                        : 8'($urandom_range(1, 6));
        c.flash_period    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                        : 8'($urandom_range(1, 10));
        c.screen_colour   = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [krcb_pkg::DATA_W-1:0] pick_key();
        logic [krcb_pkg::DATA_W-1:0] k;
        case ($urandom_range(0, 3))
            0, 1: begin
                k = LETTER_A + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 1) == 1) k = k | CASE_BIT;
            end
            2: begin
                case ($urandom_range(0, 5))
                    0: k = krcb_pkg::UPPER_BELOW;
                    1: k = krcb_pkg::UPPER_ABOVE;
                    2: k = BACKTICK;
                    3: k = OPEN_BRACE;
                    4: k = KEY_LOWEST;
                    default: k = KEY_TOP;
                endcase
            end
            default: k = 8'($urandom_range(1, 255));
        endcase
        return k;
    endfunction

    // Hold times are short, or cluster around the first repeat and the later repeat points.
    function automatic int unsigned hold_length();
        int unsigned d;
        int unsigned r;
        d = 32'(shadow_cfg.initial_delay);
        r = 32'(shadow_cfg.repeat_interval);
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 6);
            1: return d - 1 + $urandom_range(0, 2);
            default: return d + $urandom_range(1, 3) * r - 1 + $urandom_range(0, 2);
        endcase
    endfunction

    task automatic type_keys(input int unsigned budget);
        int unsigned sent;
        int unsigned hold;
        logic [krcb_pkg::DATA_W-1:0] key;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    key  = pick_key();
                    hold = hold_length();
                    if (hold > budget - sent) hold = budget - sent;
                    repeat (hold) begin
                        if ($urandom_range(0, 5) == 0) key = key ^ CASE_BIT;
                        send_poll(key);
                        sent++;
                    end
                    repeat ($urandom_range(0, 3)) begin
                        send_poll(krcb_pkg::KEY_NONE);
                        sent++;
                    end
                end
                7, 8: begin
                    repeat ($urandom_range(1, 8)) begin
                        send_poll(8'($urandom_range(0, 255)));
                        sent++;
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_poll(krcb_pkg::KEY_NONE);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    task automatic test_reset_defaults();
        send_poll(krcb_pkg::KEY_NONE);
        send_poll("A");
        send_poll("a");
        send_poll("a");
        send_poll(krcb_pkg::KEY_NONE);
        send_poll("b");
        settle();
    endtask

    task automatic test_repeat_and_release();
        load_config('{8'd2, 8'd1, 8'd1, 8'hA5});
        send_poll("q");
        send_poll("Q");
        send_poll("q");
        send_poll("q");
        send_poll("q");
        send_poll(krcb_pkg::KEY_NONE);
        send_poll(krcb_pkg::KEY_NONE);
        send_poll("Q");
        settle();
    endtask

    task automatic test_key_boundaries();
        send_poll(KEY_TOP);
        send_poll(KEY_LOWEST);
        send_poll(krcb_pkg::UPPER_BELOW);
        send_poll(BACKTICK);
        send_poll(krcb_pkg::UPPER_ABOVE);
        send_poll(OPEN_BRACE);
        send_poll("Z");
        send_poll("z");
        settle();
    endtask

    task automatic test_random_typing();
        load_config('{8'd1, 8'd1, 8'd1, 8'h00});
        type_keys(200);
        settle();
        load_config('{8'd255, 8'd255, 8'd255, 8'hFF});
        type_keys(500);
        settle();
        repeat (3) begin
            load_config(random_config());
            type_keys(200);
            settle();
        end
    endtask

    task automatic test_unbroken_stream();
        load_config(random_config());
        idling = 1'b0;
        type_keys(330);
        settle();
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        reset_typematic_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_repeat_and_release();
        test_key_boundaries();
        test_random_typing();
        test_unbroken_stream();
        $display("Checked %0d polls under %0d register settings,", polls_checked,
                 settings_used);
        $display("with random stalls on both sides. Keys delivered: %0d, cursor flips: %0d.",
                 keys_delivered, cursor_flips);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Timed out with %0d polls outstanding.", poll_results_due.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
